FILE: hw/rtl/uhb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UDP/IP header builder.
// Used by every module of the block; depends on nothing else.
package uhb_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int HDR_WORDS   = 6;

   localparam logic [CSR_INDEX_W-1:0] REG_IP_VERSION  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_ADDR_HI = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_ADDR_LO = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_ADDR_HI = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_ADDR_LO = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_PORT    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_PORT    = 3'd6;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_TOO_LONG   = 2'd1;
   localparam logic [1:0] ST_BAD_FAMILY = 2'd2;

   localparam logic [3:0]  IP_V4          = 4'd4;
   localparam logic [3:0]  IP_V6          = 4'd6;
   localparam logic [7:0]  V4_FIRST_BYTE  = 8'h45;
   localparam logic [7:0]  V6_FIRST_BYTE  = 8'h60;
   localparam logic [7:0]  TTL_VALUE      = 8'd64;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
   localparam logic [15:0] V4_HDR_BYTES   = 16'd20;
   localparam logic [15:0] MAX_PAYLOAD_V4 = 16'd65507;
   localparam logic [15:0] MAX_PAYLOAD_V6 = 16'd65487;
   localparam logic [15:0] ALL_ONES16     = 16'hffff;
   localparam logic [2:0]  V4_WORDS       = 3'd4;
   localparam logic [2:0]  V6_WORDS       = 3'd6;
   localparam logic [2:0]  ERR_WORDS      = 3'd1;

   typedef struct packed {
      logic [63:0] payload_word;
      logic [3:0]  byte_count;
      logic        last_item;
   } req_type;

   typedef struct packed {
      logic [63:0] header_word;
      logic        final_word;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [3:0]  ip_version;
      logic [63:0] src_addr_hi;
      logic [63:0] src_addr_lo;
      logic [63:0] dst_addr_hi;
      logic [63:0] dst_addr_lo;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] run_sum;
      logic [15:0] bytes;
      logic        overflow;
   } pkt_sum_type;

   // End-around carry fold of a sum of up to 256 sixteen-bit lanes.
   function automatic logic [15:0] fold24(input logic [23:0] s);
      logic [16:0] t;
      logic [16:0] u;
      t = 17'(s[15:0]) + 17'(s[23:16]);
      u = 17'(t[15:0]) + 17'(t[16]);
      return u[15:0];
   endfunction

endpackage

FILE: hw/rtl/udp_ip_header_builder.sv
`timescale 1ns / 1ps
// UDP/IP header builder top level: configuration registers and the two stages.
// Depends on uhb_pkg, uhb_accum and uhb_hdr_gen.
//
// The block takes one payload item per clock cycle while req_stall is low.
// Each item is registered and then folded into a 16-bit one's-complement sum
// and a saturating byte count. A last item hands its packet summary to the
// header generator, which builds all header words combinationally into its
// shifter and then sends them one per cycle while rsp_stall is low: four items
// for IPv4, six for IPv6 and a single item for a packet that is too long or
// has a bad address family. A last payload item passes the input register and
// the packet summary register before the shifter loads its header items. The
// output shifter is the limiting unit: a last item is held, and the input
// stalls behind it, while the summary of the packet before it still waits for
// the header generator.
// Configuration must be written only while no packet is in progress.
module udp_ip_header_builder #(
   parameter int BYTES_PER_ITEM = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [uhb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [63:0]                         csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  uhb_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output uhb_pkg::rsp_type                    rsp_data
);
   import uhb_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   pkt_sum_type pkt_sum;
   logic        pkt_sum_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_IP_VERSION: begin
               cfg_in.ip_version = csr_wdata[3:0];
            end
            REG_SRC_ADDR_HI: begin
               cfg_in.src_addr_hi = csr_wdata;
            end
            REG_SRC_ADDR_LO: begin
               cfg_in.src_addr_lo = csr_wdata;
            end
            REG_DST_ADDR_HI: begin
               cfg_in.dst_addr_hi = csr_wdata;
            end
            REG_DST_ADDR_LO: begin
               cfg_in.dst_addr_lo = csr_wdata;
            end
            REG_SRC_PORT: begin
               cfg_in.src_port = csr_wdata[15:0];
            end
            REG_DST_PORT: begin
               cfg_in.dst_port = csr_wdata[15:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{ip_version: IP_V4, src_addr_hi: '0, src_addr_lo: '0,
                     dst_addr_hi: '0, dst_addr_lo: '0, src_port: '0, dst_port: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uhb_accum #(
      .BYTES_PER_ITEM (BYTES_PER_ITEM)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .sum_out   (pkt_sum),
      .sum_stall (pkt_sum_stall)
   );

   uhb_hdr_gen u_hdr_gen (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .sum_in    (pkt_sum),
      .sum_stall (pkt_sum_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hw/rtl/uhb_accum.sv
`timescale 1ns / 1ps
// Input register and payload accumulator: one's-complement sum and byte count.
// Depends on uhb_pkg; hands a packet summary to uhb_hdr_gen.
module uhb_accum #(
   parameter int BYTES_PER_ITEM = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  uhb_pkg::req_type     req_data,
   output uhb_pkg::pkt_sum_type sum_out,
   input  logic                 sum_stall
);
   import uhb_pkg::*;

   localparam int NW    = $clog2(BYTES_PER_ITEM + 1);
   localparam int XW    = (NW > 4) ? NW : 4;
   localparam int LANES = (BYTES_PER_ITEM + 2) / 2;
   localparam int SEQ   = 2 * LANES;
   localparam int EW    = (8 * BYTES_PER_ITEM > 64) ? 8 * BYTES_PER_ITEM : 64;

   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff;
   logic [15:0]   run_sum_ff, run_sum_in;
   logic [15:0]   bytes_ff, bytes_in;
   logic          ovf_ff, ovf_in;
   logic          out_valid_ff, out_valid_in;
   logic [15:0]   out_sum_ff;
   logic [15:0]   out_bytes_ff;
   logic          out_ovf_ff;

   logic          consume;
   logic [EW-1:0] ext;
   logic [XW-1:0] count_x;
   logic [XW-1:0] bpi_x;
   logic [XW-1:0] n_x;
   logic [NW-1:0] n;
   logic [7:0]    seq [SEQ];
   logic [7:0]    byte_v;
   logic [23:0]   lane_acc;
   logic [15:0]   word_sum;
   logic [15:0]   sum_new;
   logic [16:0]   cnt_ext;
   logic [15:0]   bytes_new;
   logic          ovf_new;

   assign consume   = in_valid_ff && (!in_data_ff.last_item || !out_valid_ff || !sum_stall);
   assign req_stall = in_valid_ff && !consume;

   always_comb begin
      ext     = EW'(in_data_ff.payload_word);
      count_x = XW'(in_data_ff.byte_count);
      bpi_x   = XW'(BYTES_PER_ITEM);
      if (in_data_ff.last_item) begin
         n_x = (count_x > bpi_x) ? bpi_x : count_x;
      end else begin
         n_x = bpi_x;
      end
      n = NW'(n_x);

      for (int k = 0; k < SEQ; k++) begin
         seq[k] = 8'h00;
      end
      byte_v = 8'h00;
      for (int i = 0; i < BYTES_PER_ITEM; i++) begin
         byte_v = (NW'(i) < n) ? ext[8 * (BYTES_PER_ITEM - 1 - i) +: 8] : 8'h00;
         if (bytes_ff[0]) begin
            seq[i + 1] = byte_v;
         end else begin
            seq[i] = byte_v;
         end
      end

      lane_acc = '0;
      for (int j = 0; j < LANES; j++) begin
         lane_acc = lane_acc + 24'({seq[2 * j], seq[2 * j + 1]});
      end
      word_sum = fold24(lane_acc);
      sum_new  = fold24(24'(run_sum_ff) + 24'(word_sum));

      cnt_ext   = {1'b0, bytes_ff} + 17'(n);
      bytes_new = cnt_ext[16] ? ALL_ONES16 : cnt_ext[15:0];
      ovf_new   = ovf_ff | cnt_ext[16];
   end

   always_comb begin
      in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !consume);
      out_valid_in = (consume && in_data_ff.last_item) || (out_valid_ff && sum_stall);
      run_sum_in   = run_sum_ff;
      bytes_in     = bytes_ff;
      ovf_in       = ovf_ff;
      if (consume) begin
         if (in_data_ff.last_item) begin
            run_sum_in = '0;
            bytes_in   = '0;
            ovf_in     = 1'b0;
         end else begin
            run_sum_in = sum_new;
            bytes_in   = bytes_new;
            ovf_in     = ovf_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         run_sum_ff   <= '0;
         bytes_ff     <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         run_sum_ff   <= run_sum_in;
         bytes_ff     <= bytes_in;
         ovf_ff       <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (consume && in_data_ff.last_item) begin
         out_sum_ff   <= sum_new;
         out_bytes_ff <= bytes_new;
         out_ovf_ff   <= ovf_new;
      end
   end

   assign sum_out = '{valid: out_valid_ff, run_sum: out_sum_ff,
                      bytes: out_bytes_ff, overflow: out_ovf_ff};

`ifndef SYNTHESIS
   a_count_saturated: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> bytes_ff == ALL_ONES16)
      else $error("Overflow flag set without a saturated byte count.");

   a_packet_cleared: assert property (@(posedge clock) disable iff (reset)
      consume && in_data_ff.last_item |=> bytes_ff == '0 && !ovf_ff && run_sum_ff == '0)
      else $error("Packet state not cleared after the last item.");

   a_summary_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && sum_stall |=> out_valid_ff && $stable(out_sum_ff)
                                    && $stable(out_bytes_ff) && $stable(out_ovf_ff))
      else $error("Packet summary changed while it was stalled.");
`endif

endmodule

FILE: hw/rtl/uhb_hdr_gen.sv
`timescale 1ns / 1ps
// Header word generator: checksums, length checks and the output word shifter.
// Depends on uhb_pkg; fed by uhb_accum and the configuration registers.
module uhb_hdr_gen (
   input  logic                 clock,
   input  logic                 reset,
   input  uhb_pkg::cfg_type     cfg,
   input  uhb_pkg::pkt_sum_type sum_in,
   output logic                 sum_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output uhb_pkg::rsp_type     rsp_data
);
   import uhb_pkg::*;

   logic [15:0] v4_base_ff, v4_base_in;
   logic [15:0] src6_ff, src6_in;
   logic [15:0] dst6_ff, dst6_in;
   logic [63:0] hdr_ff [HDR_WORDS];
   logic [63:0] hdr_in [HDR_WORDS];
   logic [2:0]  left_ff, left_in;
   logic [2:0]  load_words;
   logic [1:0]  status_ff, load_status;

   logic [23:0] acc_v4, acc_src, acc_dst;
   logic        take, load;
   logic        is_v4, is_v6, too_long;
   logic [16:0] udp_len17;
   logic [15:0] udp_len, pkt_len, cks4, cks6;

   // Address, port and constant parts of both checksums, refreshed from the registers.
   always_comb begin
      acc_v4 = 24'({V4_FIRST_BYTE, 8'h00}) + 24'({TTL_VALUE, PROTO_UDP})
             + 24'(cfg.src_addr_hi[63:48]) + 24'(cfg.src_addr_hi[47:32])
             + 24'(cfg.dst_addr_hi[63:48]) + 24'(cfg.dst_addr_hi[47:32]);
      acc_src = '0;
      acc_dst = 24'(PROTO_UDP) + 24'(cfg.src_port) + 24'(cfg.dst_port);
      for (int k = 0; k < 4; k++) begin
         acc_src = acc_src + 24'(cfg.src_addr_hi[16 * k +: 16])
                           + 24'(cfg.src_addr_lo[16 * k +: 16]);
         acc_dst = acc_dst + 24'(cfg.dst_addr_hi[16 * k +: 16])
                           + 24'(cfg.dst_addr_lo[16 * k +: 16]);
      end
      v4_base_in = fold24(acc_v4);
      src6_in    = fold24(acc_src);
      dst6_in    = fold24(acc_dst);
   end

   assign take      = rsp_valid && !rsp_stall;
   assign load      = sum_in.valid && (left_ff == 3'd0 || (left_ff == 3'd1 && take));
   assign sum_stall = sum_in.valid && !load;

   always_comb begin
      is_v4     = cfg.ip_version == IP_V4;
      is_v6     = cfg.ip_version == IP_V6;
      too_long  = sum_in.overflow ||
                  (sum_in.bytes > (is_v4 ? MAX_PAYLOAD_V4 : MAX_PAYLOAD_V6));
      udp_len17 = {1'b0, sum_in.bytes} + 17'(UDP_HDR_BYTES);
      udp_len   = udp_len17[15:0];
      pkt_len   = udp_len + V4_HDR_BYTES;
      cks4      = ~fold24(24'(v4_base_ff) + 24'(pkt_len));
      cks6      = ~fold24(24'(src6_ff) + 24'(dst6_ff) + 24'(udp_len) + 24'(udp_len)
                          + 24'(sum_in.run_sum));
      if (cks6 == 16'h0000) begin
         cks6 = ALL_ONES16;
      end

      for (int k = 0; k < HDR_WORDS; k++) begin
         hdr_in[k] = '0;
      end
      if (too_long) begin
         load_words  = ERR_WORDS;
         load_status = ST_TOO_LONG;
      end else if (!is_v4 && !is_v6) begin
         load_words  = ERR_WORDS;
         load_status = ST_BAD_FAMILY;
      end else if (is_v4) begin
         load_words  = V4_WORDS;
         load_status = ST_OK;
         hdr_in[0]   = {V4_FIRST_BYTE, 8'h00, pkt_len, 32'h0};
         hdr_in[1]   = {TTL_VALUE, PROTO_UDP, cks4, cfg.src_addr_hi[63:32]};
         hdr_in[2]   = {cfg.dst_addr_hi[63:32], cfg.src_port, cfg.dst_port};
         hdr_in[3]   = {udp_len, 16'h0000, 32'h0};
      end else begin
         load_words  = V6_WORDS;
         load_status = ST_OK;
         hdr_in[0]   = {V6_FIRST_BYTE, 24'h0, udp_len, PROTO_UDP, TTL_VALUE};
         hdr_in[1]   = cfg.src_addr_hi;
         hdr_in[2]   = cfg.src_addr_lo;
         hdr_in[3]   = cfg.dst_addr_hi;
         hdr_in[4]   = cfg.dst_addr_lo;
         hdr_in[5]   = {cfg.src_port, cfg.dst_port, udp_len, cks6};
      end
   end

   always_comb begin
      left_in = left_ff;
      if (load) begin
         left_in = load_words;
      end else if (take) begin
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      v4_base_ff <= v4_base_in;
      src6_ff    <= src6_in;
      dst6_ff    <= dst6_in;
      if (load) begin
         hdr_ff    <= hdr_in;
         status_ff <= load_status;
      end else if (take) begin
         for (int k = 0; k < HDR_WORDS - 1; k++) begin
            hdr_ff[k] <= hdr_ff[k + 1];
         end
         hdr_ff[HDR_WORDS - 1] <= '0;
      end
   end

   assign rsp_valid = left_ff != 3'd0;
   assign rsp_data  = '{header_word: hdr_ff[0], final_word: left_ff == 3'd1,
                        status: status_ff};

`ifndef SYNTHESIS
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= 3'(HDR_WORDS))
      else $error("Header word count out of range.");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_ff != ST_OK |-> left_ff == 3'd1)
      else $error("Error item is not a single final item.");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      take && left_ff == 3'd1 && !sum_in.valid |=> !rsp_valid)
      else $error("Result still valid after the final header word was taken.");
`endif

endmodule
